// ----- sv/bcd_pkg.sv -----
// Package: shared types, constants and helpers of the button chord debouncer.
`default_nettype none
package bcd_pkg;

  localparam int Buttons = 2;

  localparam int PinW  = 2;
  localparam int HoldW = 16;
  localparam int TimeW = 32;
  localparam int IdxW  = 1;
  localparam int DataW = 16;

  localparam logic [HoldW-1:0] HoldReset    = 16'd75;
  localparam logic [1:0]       UsedReset    = 2'd2;

  typedef enum logic [IdxW-1:0] {
    REG_HOLD_TIME    = 1'b0,
    REG_BUTTONS_USED = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             action;
    logic [PinW-1:0]  pin_levels;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [HoldW-1:0] hold_time_ms;
    logic [PinW-1:0]  key_mask;
  } cfg_t;

  function automatic logic [PinW-1:0] key_mask_f(input logic [1:0] used);
    logic [PinW-1:0] m;
    unique case (used)
      2'd0:    m = 2'b00;
      2'd1:    m = 2'b01;
      default: m = (Buttons >= 2) ? 2'b11 : 2'b01;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- sv/bcd_item_if.sv -----
// Interface: input item channel (action, pin levels, timestamp).
`default_nettype none
interface bcd_item_if;
  import bcd_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [PinW-1:0]  pin_levels;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, action, pin_levels, now_ms, input ready);
  modport sink   (input valid, action, pin_levels, now_ms, output ready);
endinterface
`default_nettype wire

// ----- sv/bcd_result_if.sv -----
// Interface: result channel carrying the confirmed key code.
`default_nettype none
interface bcd_result_if;
  import bcd_pkg::*;
  logic            valid;
  logic            ready;
  logic [PinW-1:0] key_code;

  modport source (output valid, key_code, input ready);
  modport sink   (input valid, key_code, output ready);
endinterface
`default_nettype wire

// ----- sv/bcd_cfg_if.sv -----
// Interface: configuration register write channel.
`default_nettype none
interface bcd_cfg_if;
  import bcd_pkg::*;
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  index;
  logic [DataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/bcd_cfg_regs.sv -----
// Configuration registers: hold time and number of buttons in use.
`default_nettype none
module bcd_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  bcd_cfg_if.sink            cfg_i,
  output bcd_pkg::cfg_t      cfg_o
);
  import bcd_pkg::*;

  logic [HoldW-1:0] hold_q;
  logic [1:0]       used_q;
  logic             wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HoldReset;
      used_q <= UsedReset;
    end else if (wr) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_HOLD_TIME:    hold_q <= cfg_i.data[HoldW-1:0];
        REG_BUTTONS_USED: used_q <= cfg_i.data[1:0];
        default:          hold_q <= hold_q;
      endcase
    end
  end

  assign cfg_o.hold_time_ms = hold_q;
  assign cfg_o.key_mask     = key_mask_f(used_q);

endmodule
`default_nettype wire

// ----- sv/bcd_fsm.sv -----
// Debounce state machine: chord tracking, hold timing and result selection.
`default_nettype none
module bcd_fsm (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire bcd_pkg::item_t         item_i,
  input  wire bcd_pkg::cfg_t          cfg_i,
  output logic [bcd_pkg::PinW-1:0]    key_code_o
);
  import bcd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_PRESSED       = 3'd1,
    PH_REPORTING     = 3'd2,
    PH_AWAIT_RELEASE = 3'd3,
    PH_RELEASED      = 3'd4
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [PinW-1:0]  chord_q, chord_d;
  logic [TimeW-1:0] mark_q, mark_d;
  logic [PinW-1:0]  key;
  logic [TimeW-1:0] elapsed;
  logic             hold_passed;

  assign key         = ~item_i.pin_levels & cfg_i.key_mask;
  assign elapsed     = item_i.now_ms - mark_q;
  assign hold_passed = elapsed > {{(TimeW-HoldW){1'b0}}, cfg_i.hold_time_ms};

  always_comb begin
    phase_d    = phase_q;
    chord_d    = chord_q;
    mark_d     = mark_q;
    key_code_o = '0;
    if (item_i.action) begin
      phase_d = PH_AWAIT_RELEASE;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (key != '0) begin
            phase_d = PH_PRESSED;
            chord_d = key;
            mark_d  = item_i.now_ms;
          end
        end
        PH_PRESSED: begin
          if (key > chord_q) begin
            chord_d = key;
            mark_d  = item_i.now_ms;
          end else if (hold_passed) begin
            phase_d    = PH_REPORTING;
            key_code_o = key;
          end
        end
        PH_REPORTING: key_code_o = chord_q;
        PH_AWAIT_RELEASE: begin
          if (key == '0) begin
            phase_d = PH_RELEASED;
            mark_d  = item_i.now_ms;
          end
        end
        PH_RELEASED: begin
          if (key != '0) begin
            phase_d = PH_AWAIT_RELEASE;
          end else if (hold_passed) begin
            phase_d = PH_IDLE;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      chord_q <= '0;
      mark_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      chord_q <= chord_d;
      mark_q  <= mark_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/button_chord_debouncer_core.sv -----
// Top level: button chord debouncer with input and result registers.
// Takes one transaction per clock: each input transaction (sample or clear) is
// captured in an input register, stepped through the debounce state machine
// once the result register is free and produces exactly one key_code result in
// the result register, so throughput is one item per
// cycle while the result side keeps taking. Key code bit i is set when pin i
// is low and button i is in use; a chord is reported once it has held longer
// than hold_time_ms, then repeatedly until a clear. Configuration writes are
// always accepted and apply to items stepped after them.
`default_nettype none
module button_chord_debouncer_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  bcd_cfg_if.sink      cfg_i,
  bcd_item_if.sink     in_i,
  bcd_result_if.source out_o
);
  import bcd_pkg::*;

  cfg_t            cfg;
  logic            s1_valid_q;
  item_t           s1_item_q;
  logic            out_valid_q;
  logic [PinW-1:0] out_key_q;
  logic [PinW-1:0] fsm_key;
  logic            out_free;
  logic            advance;
  logic            take_in;

  bcd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bcd_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (s1_item_q),
    .cfg_i      (cfg),
    .key_code_o (fsm_key)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || advance;
  assign take_in    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_in) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      s1_item_q.action     <= in_i.action;
      s1_item_q.pin_levels <= in_i.pin_levels;
      s1_item_q.now_ms     <= in_i.now_ms;
    end
    if (advance) begin
      out_key_q <= fsm_key;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.key_code = out_key_q;

endmodule
`default_nettype wire

// ----- bench/bcd_checker.sv -----
// Checker: watches the debouncer channels, predicts each key code and compares.
module bcd_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  bcd_cfg_if    cfg_i,
  bcd_item_if   item_i,
  bcd_result_if res_i,
  output int    mismatches_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bcd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_PRESSED       = 3'd1,
    PH_REPORTING     = 3'd2,
    PH_AWAIT_RELEASE = 3'd3,
    PH_RELEASED      = 3'd4
  } phase_e;

  phase_e           phase;
  logic [PinW-1:0]  chord;
  logic [TimeW-1:0] mark_ms;
  logic [HoldW-1:0] hold_ms;
  logic [1:0]       used;
  logic [PinW-1:0]  code_q[$];
  int               n_bad = 0;

  assign mismatches_o = n_bad;

  task automatic report_mismatch(input string msg);
    $display("%0t bcd_checker: %s", $time, msg);
    n_bad++;
  endtask

  function automatic logic [PinW-1:0] used_mask(input logic [1:0] n);
    int unsigned k;
    k = (n > Buttons) ? Buttons : n;
    return PinW'((1 << k) - 1);
  endfunction

  function automatic logic held_long(input logic [TimeW-1:0] stamp);
    logic [TimeW-1:0] gap;
    gap = stamp - mark_ms;
    return gap > {{(TimeW-HoldW){1'b0}}, hold_ms};
  endfunction

  function automatic logic [PinW-1:0] debounce_step(input item_t it);
    logic [PinW-1:0] key;
    logic [PinW-1:0] code;
    key  = ~it.pin_levels & used_mask(used);
    code = '0;
    if (it.action) begin
      phase = PH_AWAIT_RELEASE;
      return '0;
    end
    case (phase)
      PH_IDLE: begin
        if (key != '0) begin
          phase   = PH_PRESSED;
          chord   = key;
          mark_ms = it.now_ms;
        end
      end
      PH_PRESSED: begin
        if (key > chord) begin
          chord   = key;
          mark_ms = it.now_ms;
        end else if (held_long(it.now_ms)) begin
          phase = PH_REPORTING;
          code  = key;
        end
      end
      PH_REPORTING: code = chord;
      PH_AWAIT_RELEASE: begin
        if (key == '0) begin
          phase   = PH_RELEASED;
          mark_ms = it.now_ms;
        end
      end
      PH_RELEASED: begin
        if (key != '0) begin
          phase = PH_AWAIT_RELEASE;
        end else if (held_long(it.now_ms)) begin
          phase = PH_IDLE;
        end
      end
      default: phase = PH_IDLE;
    endcase
    return code;
  endfunction

  always @(posedge clk_i) begin
    logic [PinW-1:0] want;
    if (!rst_ni) begin
      phase   = PH_IDLE;
      chord   = '0;
      mark_ms = '0;
      hold_ms = HoldReset;
      used    = UsedReset;
      code_q.delete();
    end else begin
      // pop before push: an item cannot come out in the cycle it is taken
      if (res_i.valid && res_i.ready) begin
        if (code_q.size() == 0) begin
          report_mismatch($sformatf("key_code %0d with nothing expected", res_i.key_code));
        end else begin
          want = code_q.pop_front();
          if (res_i.key_code !== want) begin
            report_mismatch($sformatf("key_code %0d, expected %0d", res_i.key_code, want));
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (reg_idx_e'(cfg_i.index))
          REG_HOLD_TIME:    hold_ms = cfg_i.data[HoldW-1:0];
          REG_BUTTONS_USED: used    = cfg_i.data[1:0];
          default:          ;
        endcase
      end
      if (item_i.valid && item_i.ready) begin
        code_q.push_back(debounce_step(item_t'{item_i.action, item_i.pin_levels,
                                               item_i.now_ms}));
      end
    end
    pending_o <= code_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: clock, reset, stimulus, flow control and verdict for the debouncer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bcd_pkg::*;

  localparam int LongHold   = 60;
  localparam int WatchLimit = 1000;

  logic clk_i = 1'b0;
  logic rst_ni;

  bcd_cfg_if    cfg_ch();
  bcd_item_if   item_ch();
  bcd_result_if res_ch();

  int          mismatches;
  int          pending;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int unsigned hold_cur     = 32'(HoldReset);
  int unsigned stamp;
  bit          hold_req     = 1'b0;
  bit          hold_ack     = 1'b0;
  int          hold_left    = 0;
  int          quiet        = 0;

  button_chord_debouncer_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (item_ch),
    .out_o  (res_ch)
  );

  bcd_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_ch),
    .item_i       (item_ch),
    .res_i        (res_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack     <= hold_req;
      hold_left    <= LongHold;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == WatchLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid      <= 1'b1;
    item_ch.action     <= it.action;
    item_ch.pin_levels <= it.pin_levels;
    item_ch.now_ms     <= it.now_ms;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
  endtask

  task automatic poke(input logic act, input logic [PinW-1:0] pins,
                      input logic [TimeW-1:0] t);
    send_item(item_t'{act, pins, t});
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input int unsigned hold, input logic [1:0] used);
    logic [DataW-1:0] d;
    settle();
    write_reg(REG_HOLD_TIME, DataW'(hold));
    d      = DataW'($urandom);
    d[1:0] = used;
    write_reg(REG_BUTTONS_USED, d);
    hold_cur = hold;
  endtask

  task automatic run_random(input int n, input int idle_pct, input int stall_pct,
                            input bit squeeze);
    item_t           it;
    int              r;
    logic [PinW-1:0] held;
    int unsigned     step_ms;
    tx_idle_pct  = idle_pct;
    rx_stall_pct <= stall_pct;
    held         = '1;
    stamp        = $urandom;
    if (squeeze) begin
      hold_req <= ~hold_req;
    end
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 12) begin
        held = PinW'($urandom_range(3));
      end else if (r < 20) begin
        held = '1;
      end
      it.action     = ($urandom_range(99) < 6);
      it.pin_levels = ($urandom_range(99) < 8) ? PinW'($urandom_range(3)) : held;
      r = $urandom_range(99);
      if (r < 65) begin
        step_ms = $urandom_range(hold_cur / 3 + 2);
      end else if (r < 85) begin
        step_ms = hold_cur + $urandom_range(2) - 1;
      end else if (r < 93) begin
        step_ms = 0;
      end else begin
        step_ms = $urandom;
      end
      stamp     += step_ms;
      it.now_ms = stamp;
      send_item(it);
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_HOLD_TIME;
    cfg_ch.data        <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.action     <= 1'b0;
    item_ch.pin_levels <= '1;
    item_ch.now_ms     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers: chord build-up, code drop, clear, release wait, time wrap
    poke(1'b0, 2'b11, 32'd100);
    poke(1'b0, 2'b10, 32'd110);
    poke(1'b0, 2'b10, 32'd185);
    poke(1'b0, 2'b00, 32'd186);
    poke(1'b0, 2'b10, 32'd262);
    poke(1'b0, 2'b11, 32'd263);
    poke(1'b1, 2'b00, 32'd264);
    poke(1'b0, 2'b01, 32'd300);
    poke(1'b0, 2'b11, 32'd301);
    poke(1'b0, 2'b10, 32'd310);
    poke(1'b0, 2'b11, 32'd320);
    poke(1'b0, 2'b11, 32'd396);
    poke(1'b0, 2'b01, 32'hFFFF_FFF0);
    poke(1'b0, 2'b11, 32'h0000_003C);
    poke(1'b0, 2'b11, 32'h0000_0040);
    poke(1'b1, 2'b11, 32'hFFFF_FFFF);
    poke(1'b0, 2'b11, 32'd0);
    poke(1'b0, 2'b11, 32'd76);

    // no buttons in use, zero hold
    set_regs(0, 2'd0);
    poke(1'b0, 2'b00, 32'd5);
    poke(1'b0, 2'b00, 32'd1000);
    poke(1'b1, 2'b00, 32'd1001);
    poke(1'b0, 2'b00, 32'd1002);
    poke(1'b0, 2'b00, 32'd1003);

    set_regs(0, 2'd1);
    poke(1'b0, 2'b00, 32'd10);
    poke(1'b0, 2'b00, 32'd10);
    poke(1'b0, 2'b00, 32'd11);

    // longest hold, oversized button count
    set_regs(65535, 2'd3);
    poke(1'b0, 2'b00, 32'd20);
    poke(1'b0, 2'b00, 32'd65555);
    poke(1'b0, 2'b00, 32'd65556);
    poke(1'b1, 2'b10, 32'd65557);

    set_regs(75, 2'd2);
    run_random(300, 0, 0, 1'b1);
    set_regs(0, 2'd2);
    run_random(250, 46, 0, 1'b0);
    set_regs(65535, 2'd2);
    run_random(250, 0, 46, 1'b0);
    set_regs(5, 2'd1);
    run_random(200, 12, 12, 1'b0);
    set_regs(20, 2'd3);
    run_random(200, 0, 0, 1'b1);
    set_regs(3, 2'd0);
    run_random(100, 0, 46, 1'b0);
    set_regs($urandom_range(1, 200), 2'd2);
    run_random(300, 12, 12, 1'b0);

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
